/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/pbrle_pkg.sv */
`default_nettype none

package pbrle_pkg;

   localparam int BYTE_W    = 8;
   localparam int ROW_W     = 16;
   localparam int CNT_W     = 3;
   localparam int LANES     = 4;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_REPEAT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_INVERT     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH = 8'd1;

   localparam logic [ROW_W-1:0]  MIN_ROW          = 16'd4;
   localparam logic [ROW_W-1:0]  ROW_LENGTH_RESET = 16'd256;
   localparam logic [BYTE_W-1:0] NOP_HEADER       = 8'h80;
   localparam logic [BYTE_W-1:0] MAX_LITERAL_HDR  = 8'd127;

   typedef struct packed {
      logic header;
      logic literal;
      logic rep_start;
      logic chunk;
   } cmd_type;

   typedef struct packed {
      logic phase_literal;
      logic phase_repeat;
      logic slot_free;
      logic chunk_final;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/pbrle_ctrl.sv */
`default_nettype none

module pbrle_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire pbrle_pkg::sts_type sts,
   output logic                   req_tready,
   output logic                   busy,
   output pbrle_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE) && sts.slot_free;
   assign accept     = req_tvalid && req_tready;
   assign busy       = (state_ff == ST_EMIT);

   always_comb begin
      cmd.literal   = accept && sts.phase_literal;
      cmd.rep_start = accept && sts.phase_repeat;
      cmd.header    = accept && !sts.phase_literal && !sts.phase_repeat;
      cmd.chunk     = (state_ff == ST_EMIT) && sts.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.rep_start) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.chunk && sts.chunk_final) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/pbrle_dp.sv */
`default_nettype none

module pbrle_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pbrle_pkg::cmd_type                   cmd,
   input  wire logic [pbrle_pkg::BYTE_W-1:0]         code_byte,
   input  wire logic                                 csr_we,
   input  wire logic [pbrle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pbrle_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  wire logic                                 rsp_tready,
   output pbrle_pkg::sts_type                        sts,
   output logic                                      rsp_tvalid,
   output logic [pbrle_pkg::LANES*pbrle_pkg::BYTE_W-1:0] lanes,
   output logic [pbrle_pkg::CNT_W-1:0]               byte_count,
   output logic                                      row_end,
   output logic                                      last
);

   logic                              invert_ff;
   logic [pbrle_pkg::ROW_W-1:0]       row_length_ff;
   logic [1:0]                        phase_ff;
   logic [1:0]                        phase_in;
   logic [pbrle_pkg::BYTE_W-1:0]      remaining_ff;
   logic [pbrle_pkg::BYTE_W-1:0]      remaining_in;
   logic [pbrle_pkg::ROW_W-1:0]       row_pos_ff;
   logic [pbrle_pkg::ROW_W-1:0]       row_pos_in;
   logic [pbrle_pkg::BYTE_W-1:0]      value_ff;
   logic                              out_valid_ff;
   logic [pbrle_pkg::LANES*pbrle_pkg::BYTE_W-1:0] lanes_ff;
   logic [pbrle_pkg::CNT_W-1:0]       count_ff;
   logic                              row_end_ff;
   logic                              last_ff;

   logic [pbrle_pkg::BYTE_W-1:0]      decoded;
   logic [pbrle_pkg::ROW_W-1:0]       eff_row;
   logic [pbrle_pkg::ROW_W-1:0]       row_left;
   logic [pbrle_pkg::CNT_W-1:0]       left_cap;
   logic [pbrle_pkg::CNT_W-1:0]       chunk_cnt;
   logic [pbrle_pkg::CNT_W-1:0]       emit_cnt;
   logic [pbrle_pkg::BYTE_W-1:0]      emit_val;
   logic                              emit;
   logic                              emit_row_end;
   logic                              emit_last;
   logic [pbrle_pkg::LANES*pbrle_pkg::BYTE_W-1:0] emit_lanes;

   assign decoded = invert_ff ? ~code_byte : code_byte;
   assign eff_row = (row_length_ff < pbrle_pkg::MIN_ROW) ? pbrle_pkg::MIN_ROW : row_length_ff;
   assign row_left = (row_pos_ff < eff_row) ? (eff_row - row_pos_ff)
                                             : {{(pbrle_pkg::ROW_W-1){1'b0}}, 1'b1};

   assign left_cap  = (remaining_ff < 8'd4) ? remaining_ff[pbrle_pkg::CNT_W-1:0] : 3'd4;
   assign chunk_cnt = (row_left < {13'd0, left_cap}) ? row_left[pbrle_pkg::CNT_W-1:0]
                                                     : left_cap;

   assign emit     = cmd.literal || cmd.chunk;
   assign emit_cnt = cmd.literal ? 3'd1 : chunk_cnt;
   assign emit_val = cmd.literal ? decoded : value_ff;
   assign emit_row_end = ({13'd0, emit_cnt} == row_left);
   assign emit_last    = cmd.literal || sts.chunk_final;

   always_comb begin
      for (int j = 0; j < pbrle_pkg::LANES; j++) begin
         emit_lanes[j*pbrle_pkg::BYTE_W +: pbrle_pkg::BYTE_W] =
            (j < int'(emit_cnt)) ? emit_val : '0;
      end
   end

   always_comb begin
      sts.phase_literal = (phase_ff == pbrle_pkg::PH_LITERAL);
      sts.phase_repeat  = (phase_ff == pbrle_pkg::PH_REPEAT);
      sts.slot_free     = !out_valid_ff || rsp_tready;
      sts.chunk_final   = (remaining_ff == {5'd0, chunk_cnt});
   end

   // decoder state
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      row_pos_in   = row_pos_ff;
      if (cmd.header) begin
         if (code_byte <= pbrle_pkg::MAX_LITERAL_HDR) begin
            remaining_in = code_byte + 8'd1;
            phase_in     = pbrle_pkg::PH_LITERAL;
         end else if (code_byte != pbrle_pkg::NOP_HEADER) begin
            remaining_in = 8'd1 - code_byte;
            phase_in     = pbrle_pkg::PH_REPEAT;
         end else begin
            phase_in     = pbrle_pkg::PH_HEADER;
         end
      end
      if (cmd.literal) begin
         remaining_in = remaining_ff - 8'd1;
         if (remaining_ff == 8'd1) begin
            phase_in = pbrle_pkg::PH_HEADER;
         end
      end
      if (cmd.chunk) begin
         remaining_in = remaining_ff - {5'd0, chunk_cnt};
         if (sts.chunk_final) begin
            phase_in = pbrle_pkg::PH_HEADER;
         end
      end
      if (emit) begin
         row_pos_in = emit_row_end ? '0 : (row_pos_ff + {13'd0, emit_cnt});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff     <= 1'b0;
         row_length_ff <= pbrle_pkg::ROW_LENGTH_RESET;
         phase_ff      <= pbrle_pkg::PH_HEADER;
         remaining_ff  <= '0;
         row_pos_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == pbrle_pkg::REG_INVERT)) begin
            invert_ff <= csr_wdata[0];
         end
         if (csr_we && (csr_index == pbrle_pkg::REG_ROW_LENGTH)) begin
            row_length_ff <= csr_wdata[pbrle_pkg::ROW_W-1:0];
         end
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         row_pos_ff   <= row_pos_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.rep_start) begin
         value_ff <= decoded;
      end
      if (emit) begin
         lanes_ff   <= emit_lanes;
         count_ff   <= emit_cnt;
         row_end_ff <= emit_row_end;
         last_ff    <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign lanes      = lanes_ff;
   assign byte_count = count_ff;
   assign row_end    = row_end_ff;
   assign last       = last_ff;

endmodule

`default_nettype wire

/* rtl/packbits_rle_decoder_core.sv */
// PackBits run-length decoder taking one compressed byte per req transaction and
// giving decoded bytes packed up to four per rsp transaction; a result never
// crosses a row of row_length bytes (csr index 1, values below 4 act as 4) and
// the result completing a row carries rsp_tuser high, while rsp_tlast marks the
// final result of an input byte. csr index 0 selects inverted (255 minus value)
// output. Header bytes are absorbed; a literal byte yields one result and a
// repeat value byte yields packed results, roughly run length / 4 plus one per
// row crossing, with req_tready low meanwhile; the controller issues one result
// per cycle into the single output register while rsp_tready is high.
`default_nettype none

`include "assert_macros.svh"

module packbits_rle_decoder_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // code_byte
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [39:0]                              rsp_tdata,  // lane0, lane1, lane2, lane3, byte_count, zero pad
   output logic                                     rsp_tuser,  // row_end
   output logic                                     rsp_tlast,
   input  wire logic                                csr_we,
   input  wire logic [pbrle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pbrle_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   pbrle_pkg::cmd_type cmd;
   pbrle_pkg::sts_type sts;
   logic               busy;
   logic [pbrle_pkg::LANES*pbrle_pkg::BYTE_W-1:0] lanes;
   logic [pbrle_pkg::CNT_W-1:0]                   byte_count;

   pbrle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .req_tready (req_tready),
      .busy       (busy),
      .cmd        (cmd)
   );

   pbrle_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .code_byte  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .lanes      (lanes),
      .byte_count (byte_count),
      .row_end    (rsp_tuser),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, byte_count, lanes};

   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset, busy, !req_tready)
   `ASSERT_IMPLIES(a_count_range, clock, reset, rsp_tvalid, (byte_count == 3'd1) || (byte_count == 3'd2) || (byte_count == 3'd3) || (byte_count == 3'd4))
   `ASSERT_IMPLIES(a_single_lane_zero, clock, reset, rsp_tvalid && (byte_count == 3'd1), lanes[31:8] == 24'd0)
   `ASSERT_NEXT(a_final_chunk_idle, clock, reset, cmd.chunk && sts.chunk_final, !busy && rsp_tlast)

endmodule

`default_nettype wire
